@@ sv/pd_wall_follow_with_hex_telemetry_unit_assert.svh @@
// Assertion macros for the wall-follow PD controller with hex telemetry
`ifndef PD_WALL_FOLLOW_WITH_HEX_TELEMETRY_UNIT_ASSERT_SVH
`define PD_WALL_FOLLOW_WITH_HEX_TELEMETRY_UNIT_ASSERT_SVH

// check cons in the same cycle as ante
`define PDWF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define PDWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pdwf_pkg.sv @@
// Package: constants, control word type, hex character function and microcode table of the PD telemetry unit
package pdwf_pkg;

  localparam int SAMPLES_PER_FRAME_DEF = 10;

  localparam int ERR_W   = 12;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 8;
  localparam int CORR_W  = 13;
  localparam int CHAR_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int PC_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR = 3'd4;

  localparam logic [ERR_W-1:0]  RST_SETPOINT  = 12'd2500;
  localparam logic [GAIN_W-1:0] RST_P_GAIN    = 16'd5243;
  localparam logic [GAIN_W-1:0] RST_D_GAIN    = 16'd3277;
  localparam logic [LIM_W-1:0]  RST_LIMIT     = 8'd60;
  localparam logic [ERR_W-1:0]  RST_FRONT_THR = 12'd2000;

  localparam logic KIND_CTRL = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 8'h34;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_DIGIT_BASE = 8'd48;
  localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 8'd55;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_CTRL  = 2'd1;
  localparam logic [1:0] SRC_CONST = 2'd2;
  localparam logic [1:0] SRC_HEX   = 2'd3;

  localparam logic [1:0] J_NEXT     = 2'd0;
  localparam logic [1:0] J_ALWAYS   = 2'd1;
  localparam logic [1:0] J_NOFRAME  = 2'd2;
  localparam logic [1:0] J_MORE     = 2'd3;

  localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] ST_ERR   = 4'd1;
  localparam logic [PC_W-1:0] ST_MUL   = 4'd2;
  localparam logic [PC_W-1:0] ST_CTRL  = 4'd3;
  localparam logic [PC_W-1:0] ST_HDR0  = 4'd4;
  localparam logic [PC_W-1:0] ST_HDR1  = 4'd5;
  localparam logic [PC_W-1:0] ST_HDR2  = 4'd6;
  localparam logic [PC_W-1:0] ST_DIG3  = 4'd7;
  localparam logic [PC_W-1:0] ST_DIG2  = 4'd8;
  localparam logic [PC_W-1:0] ST_DIG1  = 4'd9;
  localparam logic [PC_W-1:0] ST_DIG0  = 4'd10;
  localparam logic [PC_W-1:0] ST_LOOP  = 4'd11;
  localparam logic [PC_W-1:0] ST_TRL0  = 4'd12;
  localparam logic [PC_W-1:0] ST_TRL1  = 4'd13;
  localparam logic [PC_W-1:0] ST_TRL2  = 4'd14;
  localparam logic [PC_W-1:0] ST_TRL3  = 4'd15;

  typedef struct packed {
    logic              wait_in;
    logic              emit;
    logic [1:0]        src;
    logic [CHAR_W-1:0] ch;
    logic [1:0]        nib;
    logic              last;
    logic [1:0]        jmp;
    logic [PC_W-1:0]   target;
    logic              do_err;
    logic              do_mul;
    logic              init_rd;
    logic              next_smp;
  } ctrl_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] r;
    r = (v < 4'd10) ? (CH_DIGIT_BASE + CHAR_W'(v)) : (CH_ALPHA_BASE + CHAR_W'(v));
    return r;
  endfunction

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      ST_IDLE: begin
        w.wait_in = 1'b1;
      end
      ST_ERR: begin
        w.do_err = 1'b1;
      end
      ST_MUL: begin
        w.do_mul = 1'b1;
      end
      ST_CTRL: begin
        w.emit = 1'b1; w.src = SRC_CTRL; w.init_rd = 1'b1;
        w.jmp = J_NOFRAME; w.target = ST_IDLE;
      end
      ST_HDR0: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_COLON;
      end
      ST_HDR1: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_TWO;
      end
      ST_HDR2: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_FOUR;
      end
      ST_DIG3: begin
        w.emit = 1'b1; w.src = SRC_HEX; w.nib = 2'd3;
      end
      ST_DIG2: begin
        w.emit = 1'b1; w.src = SRC_HEX; w.nib = 2'd2;
      end
      ST_DIG1: begin
        w.emit = 1'b1; w.src = SRC_HEX; w.nib = 2'd1;
      end
      ST_DIG0: begin
        w.emit = 1'b1; w.src = SRC_HEX; w.nib = 2'd0; w.next_smp = 1'b1;
      end
      ST_LOOP: begin
        w.jmp = J_MORE; w.target = ST_DIG3;
      end
      ST_TRL0: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_TWO;
      end
      ST_TRL1: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_FOUR;
      end
      ST_TRL2: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_CR;
      end
      ST_TRL3: begin
        w.emit = 1'b1; w.src = SRC_CONST; w.ch = CH_LF; w.last = 1'b1;
        w.jmp = J_ALWAYS; w.target = ST_IDLE;
      end
      default: begin
        w.jmp = J_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ sv/pd_wall_follow_with_hex_telemetry_unit.sv @@
// Top level: microcoded PD wall-follow controller with hex telemetry framing
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: side, front, collect
//  out_    | master    | out_tvalid/out_tready| out_tdata, out_tuser kind, out_tlast
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// An item without a frame passes the accept, error, multiply and control result steps.
// A frame item continues with the header, then the sequencer walks the samples through the
// registered sample memory read port (four hex digits and a loop step each), then the trailer.
// Synchronous active-low reset loads config defaults and resets loop state, sequencer and output valid.
// A stalled output holds the sequencer on its emit step; a new item is accepted
// while the last result still waits in the output register.
module pd_wall_follow_with_hex_telemetry_unit #(
  parameter int SAMPLES_PER_FRAME = pdwf_pkg::SAMPLES_PER_FRAME_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [11:0] side_distance, [23:12] front_distance, [24] collect_enable, [31:25] zero
  input  logic [pdwf_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [12:0] correction, [13] saturated, [14] front_obstacle, [22:15] tx_char, [23] zero
  output logic [pdwf_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] result_kind
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdwf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdwf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = 2 * SAMPLES_PER_FRAME;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(SAMPLES_PER_FRAME + 1);
  localparam int EW    = pdwf_pkg::ERR_W;

  logic [EW-1:0]                  setpoint_r;
  logic [pdwf_pkg::GAIN_W-1:0]    p_gain_r;
  logic [pdwf_pkg::GAIN_W-1:0]    d_gain_r;
  logic [pdwf_pkg::LIM_W-1:0]     limit_r;
  logic [EW-1:0]                  front_thr_r;

  logic [pdwf_pkg::PC_W-1:0]      pc_r, pc_nxt;
  pdwf_pkg::ctrl_t                ctl;
  logic                           out_free, stall, in_accept;

  logic [EW-1:0]                  side_r, front_r;
  logic                           collect_r;
  logic [EW-1:0]                  prev_err_r;
  logic [pdwf_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic                           bank_r, bank_nxt;
  logic                           phase_r;
  logic                           frame_r;
  logic [AW-1:0]                  base_r;
  logic [AW-1:0]                  wr_addr;

  logic [EW-1:0]                  err_c, err_r;
  logic [EW:0]                    diff_c;
  logic [EW-1:0]                  mag_c, mag_r;
  logic                           neg_r;
  logic [27:0]                    prod_p, prod_d;
  logic [EW-1:0]                  pterm_r, dmag_r;
  logic [13:0]                    sum_p, sum_d, corr_sum;
  logic                           sat_c;
  logic [pdwf_pkg::CORR_W-1:0]    corr_c;

  logic [EW-1:0]                  mem [DEPTH];
  logic [AW-1:0]                  rd_addr_r;
  logic [EW-1:0]                  rd_data_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [3:0]                     nibble;

  logic                           out_valid_r;
  logic                           out_kind_r;
  logic [pdwf_pkg::CORR_W-1:0]    out_corr_r;
  logic                           out_sat_r;
  logic                           out_obst_r;
  logic [pdwf_pkg::CHAR_W-1:0]    out_char_r;
  logic                           out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= pdwf_pkg::RST_SETPOINT;
      p_gain_r    <= pdwf_pkg::RST_P_GAIN;
      d_gain_r    <= pdwf_pkg::RST_D_GAIN;
      limit_r     <= pdwf_pkg::RST_LIMIT;
      front_thr_r <= pdwf_pkg::RST_FRONT_THR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdwf_pkg::REG_SETPOINT:  setpoint_r  <= cfg_data[EW-1:0];
        pdwf_pkg::REG_P_GAIN:    p_gain_r    <= cfg_data;
        pdwf_pkg::REG_D_GAIN:    d_gain_r    <= cfg_data;
        pdwf_pkg::REG_LIMIT:     limit_r     <= cfg_data[pdwf_pkg::LIM_W-1:0];
        pdwf_pkg::REG_FRONT_THR: front_thr_r <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign ctl       = pdwf_pkg::rom_word(pc_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = ctl.wait_in;
  assign in_accept = in_tvalid && in_tready;
  assign stall     = (ctl.wait_in && !in_tvalid) || (ctl.emit && !out_free);

  always_comb begin
    pc_nxt = pc_r;
    if (!stall) begin
      case (ctl.jmp)
        pdwf_pkg::J_NEXT:    pc_nxt = pc_r + 1'b1;
        pdwf_pkg::J_ALWAYS:  pc_nxt = ctl.target;
        pdwf_pkg::J_NOFRAME: pc_nxt = frame_r ? pc_r + 1'b1 : ctl.target;
        pdwf_pkg::J_MORE:    pc_nxt = (cnt_r != CNT_W'(SAMPLES_PER_FRAME)) ?
                                      ctl.target : pc_r + 1'b1;
        default:             pc_nxt = pdwf_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pdwf_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      side_r    <= in_tdata[11:0];
      front_r   <= in_tdata[23:12];
      collect_r <= in_tdata[24];
    end
  end

  // error, derivative and logging
  assign err_c  = (side_r >= setpoint_r) ? (side_r - setpoint_r) : (setpoint_r - side_r);
  assign diff_c = {1'b0, err_c} - {1'b0, prev_err_r};
  assign mag_c  = diff_c[EW] ? 12'(-diff_c) : diff_c[EW-1:0];

  assign slot_nxt = (slot_r >= pdwf_pkg::SLOT_W'(SAMPLES_PER_FRAME - 1)) ?
                    '0 : slot_r + 1'b1;
  assign bank_nxt = (slot_nxt == '0) ? !bank_r : bank_r;
  assign wr_addr  = (bank_nxt ? AW'(SAMPLES_PER_FRAME) : AW'(0)) + AW'(slot_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      slot_r     <= pdwf_pkg::SLOT_W'(SAMPLES_PER_FRAME - 1);
      bank_r     <= 1'b0;
      phase_r    <= 1'b0;
      frame_r    <= 1'b0;
    end else if (ctl.do_err) begin
      prev_err_r <= err_c;
      phase_r    <= collect_r ? !phase_r : 1'b0;
      frame_r    <= 1'b0;
      if (phase_r) begin
        slot_r  <= slot_nxt;
        bank_r  <= bank_nxt;
        frame_r <= (slot_nxt == pdwf_pkg::SLOT_W'(SAMPLES_PER_FRAME - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_err) begin
      err_r <= err_c;
      mag_r <= mag_c;
      neg_r <= diff_c[EW];
      if (phase_r) begin
        base_r <= bank_nxt ? AW'(SAMPLES_PER_FRAME) : AW'(0);
      end
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (ctl.do_err && phase_r) begin
      mem[wr_addr] <= err_c;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // gain products
  assign prod_p = 28'(p_gain_r) * 28'(err_r);
  assign prod_d = 28'(d_gain_r) * 28'(mag_r);

  always_ff @(posedge clk) begin
    if (ctl.do_mul) begin
      pterm_r <= prod_p[27:16];
      dmag_r  <= prod_d[27:16];
    end
  end

  assign sum_p    = {2'b00, pterm_r};
  assign sum_d    = neg_r ? 14'(-{2'b00, dmag_r}) : {2'b00, dmag_r};
  assign corr_sum = sum_p + sum_d;
  assign sat_c    = $signed(corr_sum) > $signed({6'd0, limit_r});
  assign corr_c   = sat_c ? {5'd0, limit_r} : corr_sum[pdwf_pkg::CORR_W-1:0];

  // frame read pointer and sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_addr_r <= '0;
    end else if (!stall && ctl.init_rd) begin
      cnt_r     <= '0;
      rd_addr_r <= base_r;
    end else if (!stall && ctl.next_smp) begin
      cnt_r     <= cnt_r + 1'b1;
      rd_addr_r <= (cnt_r == CNT_W'(SAMPLES_PER_FRAME - 1)) ? base_r : rd_addr_r + 1'b1;
    end
  end

  always_comb begin
    case (ctl.nib)
      2'd3:    nibble = 4'd0;
      2'd2:    nibble = rd_data_r[11:8];
      2'd1:    nibble = rd_data_r[7:4];
      default: nibble = rd_data_r[3:0];
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      if (ctl.src == pdwf_pkg::SRC_CTRL) begin
        out_kind_r <= pdwf_pkg::KIND_CTRL;
        out_corr_r <= corr_c;
        out_sat_r  <= sat_c;
        out_obst_r <= (front_r > front_thr_r);
        out_char_r <= '0;
        out_last_r <= !frame_r;
      end else begin
        out_kind_r <= pdwf_pkg::KIND_CHAR;
        out_corr_r <= '0;
        out_sat_r  <= 1'b0;
        out_obst_r <= 1'b0;
        out_char_r <= (ctl.src == pdwf_pkg::SRC_HEX) ? pdwf_pkg::hex_char(nibble) : ctl.ch;
        out_last_r <= ctl.last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_char_r, out_obst_r, out_sat_r, out_corr_r};

`include "pd_wall_follow_with_hex_telemetry_unit_assert.svh"

  `PDWF_ASSERT_NEXT(a_accept_to_err, in_accept, pc_r == pdwf_pkg::ST_ERR, "no error step")
  `PDWF_ASSERT_NEXT(a_emit_stall_hold, ctl.emit && !out_free, $stable(pc_r), "stall moved pc")
  `PDWF_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(SAMPLES_PER_FRAME), "count overrun")
  `PDWF_ASSERT_NOW(a_rd_range, 1'b1, 32'(rd_addr_r) < 32'(DEPTH), "read address overrun")
  `PDWF_ASSERT_NOW(a_ctrl_nochar, out_valid_r && out_kind_r == pdwf_pkg::KIND_CTRL,
                   out_char_r == '0, "char on control result")

endmodule
